/* src/point_segment_projection_top_defines.svh */
// Assertion macros used by the projection top module.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef POINT_SEGMENT_PROJECTION_TOP_DEFINES_SVH
`define POINT_SEGMENT_PROJECTION_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define PSP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m: check failed");
`define PSP_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("%m: check failed");
`else
`define PSP_ASSERT(label, clk, rst, prop)
`define PSP_ASSERT_NR(label, clk, prop)
`endif
`endif

/* src/psp_pkg.sv */
// Shared types and constants for the point to segment projection block.
// No dependencies.
`default_nettype none
package psp_pkg;
   localparam int CoordWidth = 32;
   localparam int LambdaBits = 16;
   localparam int NumAxes    = 3;
   localparam int DiffWidth  = CoordWidth + 1;
   localparam int ProdWidth  = 2 * DiffWidth;
   localparam int SumWidth   = ProdWidth + 2;
   localparam int FracWidth  = LambdaBits + 1;

   typedef logic signed [CoordWidth-1:0] coord_type;
   typedef logic signed [DiffWidth-1:0]  diff_type;
   typedef logic signed [ProdWidth-1:0]  prod_type;
   typedef logic signed [SumWidth-1:0]   sum_type;
   typedef logic [FracWidth-1:0]         frac_type;

   typedef struct packed {
      coord_type point_x;
      coord_type point_y;
      coord_type point_z;
      coord_type start_x;
      coord_type start_y;
      coord_type start_z;
      coord_type end_x;
      coord_type end_y;
      coord_type end_z;
   } req_type;

   typedef struct packed {
      coord_type proj_x;
      coord_type proj_y;
      coord_type proj_z;
      frac_type  fraction;
      logic      degenerate;
   } rsp_type;

   // outcome class of one query
   typedef enum logic [1:0] {
      CLS_START, CLS_END, CLS_INSIDE, CLS_DEGEN
   } cls_type;

   function automatic coord_type sat_coord(input logic signed [CoordWidth+1:0] v);
      logic signed [CoordWidth+1:0] hi_lim;
      logic signed [CoordWidth+1:0] lo_lim;
      hi_lim = (CoordWidth+2)'(signed'({1'b0, {(CoordWidth-1){1'b1}}}));
      lo_lim = -hi_lim - (CoordWidth+2)'(1);
      if (v > hi_lim) return coord_type'(hi_lim[CoordWidth-1:0]);
      if (v < lo_lim) return coord_type'(lo_lim[CoordWidth-1:0]);
      return v[CoordWidth-1:0];
   endfunction
endpackage
`default_nettype wire

/* src/psp_lane.sv */
// One axis lane: differences, then the two products of that axis, registered.
// Depends on psp_pkg.
`default_nettype none
module psp_lane import psp_pkg::*; (
   input  wire logic      clock,
   input  wire coord_type point_in,
   input  wire coord_type start_in,
   input  wire coord_type end_in,
   output prod_type       dot_term,
   output prod_type       len_term,
   output diff_type       edge_out
);
   diff_type d_ff, e_ff, d_in, e_in;
   prod_type dot_ff, len_ff;
   diff_type e2_ff;

   // form point and edge offsets
   always_comb begin
      d_in = DiffWidth'(point_in) - DiffWidth'(start_in);
      e_in = DiffWidth'(end_in) - DiffWidth'(start_in);
   end

   // register offsets, then products
   always_ff @(posedge clock) begin
      d_ff   <= d_in;
      e_ff   <= e_in;
      dot_ff <= ProdWidth'(d_ff) * ProdWidth'(e_ff);
      len_ff <= ProdWidth'(e_ff) * ProdWidth'(e_ff);
      e2_ff  <= e_ff;
   end

   assign dot_term = dot_ff;
   assign len_term = len_ff;
   assign edge_out = e2_ff;
endmodule
`default_nettype wire

/* src/psp_divider.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Depends on psp_pkg.
`default_nettype none
module psp_divider import psp_pkg::*; (
   input  wire logic     clock,
   input  wire sum_type  num_in,
   input  wire sum_type  den_in,
   output frac_type      quot_out
);
   sum_type  rem_ff [1:LambdaBits];
   sum_type  den_ff [1:LambdaBits];
   frac_type q_ff   [1:LambdaBits];

   // one shift and trial subtract per stage
   for (genvar k = 0; k < LambdaBits; k++) begin : g_stage
      sum_type  rem_cur;
      sum_type  den_cur;
      frac_type q_cur;
      logic [SumWidth:0] sh;
      logic [SumWidth:0] diff;

      // first stage takes the divider inputs, later ones the previous stage
      if (k == 0) begin : g_first
         assign rem_cur = num_in;
         assign den_cur = den_in;
         assign q_cur   = '0;
      end else begin : g_next
         assign rem_cur = rem_ff[k];
         assign den_cur = den_ff[k];
         assign q_cur   = q_ff[k];
      end

      assign sh   = {rem_cur, 1'b0};
      assign diff = sh - {1'b0, den_cur};
      always_ff @(posedge clock) begin
         den_ff[k+1] <= den_cur;
         if (!diff[SumWidth]) begin
            rem_ff[k+1] <= diff[SumWidth-1:0];
            q_ff[k+1]   <= {q_cur[FracWidth-2:0], 1'b1};
         end else begin
            rem_ff[k+1] <= sh[SumWidth-1:0];
            q_ff[k+1]   <= {q_cur[FracWidth-2:0], 1'b0};
         end
      end
   end

   assign quot_out = q_ff[LambdaBits];
endmodule
`default_nettype wire

/* src/point_segment_projection_top.sv */
// Closest point on a 3D segment: three axis lanes, divider, merge stage.
// One query accepted every cycle.
// The lane multipliers and the one-bit-per-stage divider set the latency.
// busy is always low; the receiver cannot stall and every query yields one strobe.
// Synchronous active-high reset clears the valid pipeline only.
// Depends on psp_pkg, psp_lane, psp_divider and the defines header.
`default_nettype none
`include "point_segment_projection_top_defines.svh"
module point_segment_projection_top import psp_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);
   localparam int Latency = LambdaBits + 5;
   localparam int Hold    = LambdaBits + 2;

   coord_type p_ax [NumAxes];
   coord_type a_ax [NumAxes];
   coord_type b_ax [NumAxes];
   prod_type  dterm [NumAxes];
   prod_type  lterm [NumAxes];
   diff_type  edge_ax [NumAxes];

   assign p_ax = '{req_data.point_x, req_data.point_y, req_data.point_z};
   assign a_ax = '{req_data.start_x, req_data.start_y, req_data.start_z};
   assign b_ax = '{req_data.end_x, req_data.end_y, req_data.end_z};

   for (genvar i = 0; i < NumAxes; i++) begin : g_lane
      psp_lane u_lane (
         .clock(clock), .point_in(p_ax[i]), .start_in(a_ax[i]), .end_in(b_ax[i]),
         .dot_term(dterm[i]), .len_term(lterm[i]), .edge_out(edge_ax[i])
      );
   end

   logic [Latency-1:0] vld_ff;
   assign busy = 1'b0;

   // advance valid marks
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else vld_ff <= {vld_ff[Latency-2:0], start};
   end

   // delay start and end coordinates alongside the lanes
   coord_type a_dly_ff [Hold+1][NumAxes];
   coord_type b_dly_ff [3][NumAxes];
   always_ff @(posedge clock) begin
      a_dly_ff[0] <= a_ax;
      b_dly_ff[0] <= b_ax;
      for (int s = 1; s <= Hold; s++) a_dly_ff[s] <= a_dly_ff[s-1];
      b_dly_ff[1] <= b_dly_ff[0];
      b_dly_ff[2] <= b_dly_ff[1];
   end

   // merge lane products and classify
   sum_type dot_ff, len_ff;
   always_ff @(posedge clock) begin
      dot_ff <= SumWidth'(dterm[0]) + SumWidth'(dterm[1]) + SumWidth'(dterm[2]);
      len_ff <= SumWidth'(lterm[0]) + SumWidth'(lterm[1]) + SumWidth'(lterm[2]);
   end

   cls_type cls_in;
   always_comb begin
      priority if (len_ff == '0) cls_in = CLS_DEGEN;
      else if (dot_ff <= 0) cls_in = CLS_START;
      else if (dot_ff >= len_ff) cls_in = CLS_END;
      else cls_in = CLS_INSIDE;
   end

   logic [SumWidth-1:0] num_sel;
   assign num_sel = (cls_in == CLS_INSIDE) ? dot_ff : '0;

   frac_type quot;
   psp_divider u_div (.clock(clock), .num_in(num_sel), .den_in(len_ff), .quot_out(quot));

   // carry class, edges and end point through the divider latency
   cls_type  cls_dly_ff [LambdaBits+1];
   diff_type e_dly_ff [LambdaBits+1][NumAxes];
   coord_type b_hold_ff [LambdaBits+1][NumAxes];
   always_ff @(posedge clock) begin
      cls_dly_ff[0] <= cls_in;
      e_dly_ff[0]   <= edge_ax;
      b_hold_ff[0]  <= b_dly_ff[2];
      for (int s = 1; s <= LambdaBits; s++) begin
         cls_dly_ff[s] <= cls_dly_ff[s-1];
         e_dly_ff[s]   <= e_dly_ff[s-1];
         b_hold_ff[s]  <= b_hold_ff[s-1];
      end
   end

   // scale edge by fraction, registered
   localparam int MulWidth = DiffWidth + FracWidth + 1;
   logic signed [MulWidth-1:0] mul_ff [NumAxes];
   cls_type   cls_m_ff;
   frac_type  q_m_ff;
   coord_type a_m_ff [NumAxes];
   coord_type b_m_ff [NumAxes];
   always_ff @(posedge clock) begin
      for (int i = 0; i < NumAxes; i++)
         mul_ff[i] <= MulWidth'(e_dly_ff[LambdaBits][i]) *
                      MulWidth'(signed'({1'b0, quot}));
      cls_m_ff <= cls_dly_ff[LambdaBits-1];
      q_m_ff   <= quot;
      a_m_ff   <= a_dly_ff[Hold];
      b_m_ff   <= b_hold_ff[LambdaBits-1];
   end

   // round, add start, saturate, select by class
   rsp_type rsp_ff, rsp_in;
   always_comb begin
      logic signed [MulWidth-1:0] rnd;
      logic signed [CoordWidth+1:0] sum [NumAxes];
      coord_type r [NumAxes];
      for (int i = 0; i < NumAxes; i++) begin
         rnd    = (mul_ff[i] + MulWidth'(1 << (LambdaBits-1))) >>> LambdaBits;
         sum[i] = (CoordWidth+2)'(a_m_ff[i]) + (CoordWidth+2)'(rnd);
         r[i]   = sat_coord(sum[i]);
      end
      rsp_in = '0;
      unique case (cls_m_ff)
         CLS_DEGEN: begin
            rsp_in.proj_x = a_m_ff[0]; rsp_in.proj_y = a_m_ff[1];
            rsp_in.proj_z = a_m_ff[2]; rsp_in.degenerate = 1'b1;
         end
         CLS_START: begin
            rsp_in.proj_x = a_m_ff[0]; rsp_in.proj_y = a_m_ff[1];
            rsp_in.proj_z = a_m_ff[2];
         end
         CLS_END: begin
            rsp_in.proj_x = b_m_ff[0]; rsp_in.proj_y = b_m_ff[1];
            rsp_in.proj_z = b_m_ff[2];
            rsp_in.fraction = FracWidth'(1 << LambdaBits);
         end
         CLS_INSIDE: begin
            rsp_in.proj_x = r[0]; rsp_in.proj_y = r[1]; rsp_in.proj_z = r[2];
            rsp_in.fraction = q_m_ff;
         end
         default: rsp_in = '0;
      endcase
   end

   always_ff @(posedge clock) rsp_ff <= rsp_in;

   assign rsp_data   = rsp_ff;
   assign rsp_strobe = vld_ff[Latency-1];

   `PSP_ASSERT(a_lat, clock, reset, start |-> ##21 rsp_strobe)
   `PSP_ASSERT(a_frac, clock, reset, rsp_strobe |-> rsp_data.fraction <= 17'd65536)
   `PSP_ASSERT(a_degen, clock, reset, rsp_strobe && rsp_data.degenerate |-> rsp_data.fraction == 17'd0)
   `PSP_ASSERT_NR(a_busy, clock, !busy)
endmodule
`default_nettype wire
